// File: rtl/core/ndp_pkg.sv
package ndp_pkg;

	// section tags, also used as the parser phase
	typedef enum logic [2:0] {
		SEC_HEADER  = 3'd0,
		SEC_TYPELEN = 3'd1,
		SEC_PAYLEN  = 3'd2,
		SEC_IDLEN   = 3'd3,
		SEC_TYPE    = 3'd4,
		SEC_ID      = 3'd5,
		SEC_PAYLOAD = 3'd6,
		SEC_IGNORE  = 3'd7
	} sec_t;

	typedef enum logic [1:0] {
		ST_BUSY  = 2'd0,
		ST_VALID = 2'd1,
		ST_ERROR = 2'd2
	} status_t;

	// header byte bit positions
	localparam int unsigned HDR_MB = 7;
	localparam int unsigned HDR_ME = 6;
	localparam int unsigned HDR_SR = 4;
	localparam int unsigned HDR_IL = 3;

	localparam logic [2:0] TNF_EMPTY     = 3'd0;
	localparam logic [2:0] TNF_UNKNOWN   = 3'd5;
	localparam logic [2:0] TNF_UNCHANGED = 3'd6;

	// last byte of a long payload length
	localparam logic [1:0] LEN_LAST = 2'd3;

	localparam logic [7:0] REC_MAX = 8'hff;

	typedef struct packed {
		sec_t        phase;
		logic [7:0]  header;
		logic [7:0]  type_len;
		logic [31:0] pay_len;
		logic [7:0]  id_len;
		logic [1:0]  len_cnt;
		logic [31:0] remaining;
		logic [7:0]  rec_cnt;
		logic        error_seen;
		logic        ended;
		logic        first_pending;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase:         SEC_HEADER,
		header:        8'd0,
		type_len:      8'd0,
		pay_len:       32'd0,
		id_len:        8'd0,
		len_cnt:       2'd0,
		remaining:     32'd0,
		rec_cnt:       8'd0,
		error_seen:    1'b0,
		ended:         1'b0,
		first_pending: 1'b1
	};

	typedef struct packed {
		logic [7:0]  out_byte;
		sec_t        section;
		logic [7:0]  record_number;
		logic        header_done;
		logic [4:0]  record_flags;
		logic [2:0]  record_tnf;
		logic [7:0]  type_len;
		logic [31:0] payload_length;
		logic [7:0]  id_len;
		status_t     status;
	} result_t;

endpackage

// File: rtl/core/ndp_in_if.sv
interface ndp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, output data_byte, output last_byte, input ready);
	modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

// File: rtl/core/ndp_out_if.sv
interface ndp_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic [2:0]  section;
	logic [7:0]  record_number;
	logic        header_done;
	logic [4:0]  record_flags;
	logic [2:0]  record_tnf;
	logic [7:0]  type_len;
	logic [31:0] payload_length;
	logic [7:0]  id_len;
	logic [1:0]  status;

	modport source(output valid, output out_byte, output section, output record_number,
		output header_done, output record_flags, output record_tnf, output type_len,
		output payload_length, output id_len, output status, input ready);
	modport sink(input valid, input out_byte, input section, input record_number,
		input header_done, input record_flags, input record_tnf, input type_len,
		input payload_length, input id_len, input status, output ready);
endinterface

// File: rtl/core/ndef_message_parser_core.sv
// Streaming NDEF message parser: takes one raw message byte per item on raw and returns one
// tagged item per byte on parsed, with the section, record index, header flags, lengths and
// message status after that byte. One byte is accepted every cycle while the output buffer
// has space; the result is registered in that buffer. A two-entry output buffer (head plus
// skid register) keeps raw.ready independent of parsed.ready, so input stalls only once two
// results wait. The byte marked last_byte closes the message and the parser is ready for a
// new one on the next cycle. No clearing pass is needed after reset.
module ndef_message_parser_core (
	input  logic       clk,
	input  logic       arst_n,
	ndp_in_if.sink     raw,
	ndp_out_if.source  parsed
);

	ndp_pkg::state_t  state_q;
	ndp_pkg::state_t  state_d;
	ndp_pkg::result_t step_res;
	ndp_pkg::result_t out_res;
	logic             accept;
	logic             space;

	assign accept = raw.valid && raw.ready;
	assign raw.ready = space;

	ndp_step u_step (
		.cur       (state_q),
		.data_byte (raw.data_byte),
		.last_byte (raw.last_byte),
		.nxt       (state_d),
		.res       (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ndp_pkg::STATE_RESET;
		end else if (accept) begin
			state_q <= state_d;
		end
	end

	ndp_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (step_res),
		.space     (space),
		.valid     (parsed.valid),
		.data      (out_res),
		.take      (parsed.ready)
	);

	assign parsed.out_byte = out_res.out_byte;
	assign parsed.section = out_res.section;
	assign parsed.record_number = out_res.record_number;
	assign parsed.header_done = out_res.header_done;
	assign parsed.record_flags = out_res.record_flags;
	assign parsed.record_tnf = out_res.record_tnf;
	assign parsed.type_len = out_res.type_len;
	assign parsed.payload_length = out_res.payload_length;
	assign parsed.id_len = out_res.id_len;
	assign parsed.status = out_res.status;

`ifndef ASSERT_OFF
	a_last_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		accept && raw.last_byte |=> state_q.first_pending && state_q.phase == ndp_pkg::SEC_HEADER)
		else $error("parser not rearmed after last byte");
	a_error_ignores: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.error_seen |-> state_q.phase == ndp_pkg::SEC_IGNORE)
		else $error("parsing continues after format error");
	a_end_ignores: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.ended |-> state_q.phase == ndp_pkg::SEC_IGNORE)
		else $error("parsing continues after end record");
`endif

endmodule

// File: rtl/core/ndp_step.sv
module ndp_step (
	input  ndp_pkg::state_t  cur,
	input  logic [7:0]       data_byte,
	input  logic             last_byte,
	output ndp_pkg::state_t  nxt,
	output ndp_pkg::result_t res
);

	// move to the first non-empty data section after the given one, else end the record
	function automatic ndp_pkg::state_t advance(ndp_pkg::state_t st, ndp_pkg::sec_t after);
		ndp_pkg::state_t r;
		r = st;
		if (after < ndp_pkg::SEC_TYPE && st.type_len != 8'd0) begin
			r.phase = ndp_pkg::SEC_TYPE;
			r.remaining = {24'd0, st.type_len};
		end else if (after < ndp_pkg::SEC_ID && st.id_len != 8'd0) begin
			r.phase = ndp_pkg::SEC_ID;
			r.remaining = {24'd0, st.id_len};
		end else if (after < ndp_pkg::SEC_PAYLOAD && st.pay_len != 32'd0) begin
			r.phase = ndp_pkg::SEC_PAYLOAD;
			r.remaining = st.pay_len;
		end else if (st.header[ndp_pkg::HDR_ME]) begin
			r.ended = 1'b1;
			r.phase = ndp_pkg::SEC_IGNORE;
		end else begin
			r.phase = ndp_pkg::SEC_HEADER;
		end
		return r;
	endfunction

	ndp_pkg::state_t n;
	ndp_pkg::sec_t   sec;
	logic            hd;
	logic            complete;
	logic            adv;
	logic            bad;
	logic [31:0]     rem_dec;
	logic [2:0]      tnf;
	ndp_pkg::status_t st;

	assign rem_dec = (cur.remaining != 32'd0) ? cur.remaining - 32'd1 : cur.remaining;

	always_comb begin
		n = cur;
		sec = cur.phase;
		hd = 1'b0;
		complete = 1'b0;
		adv = 1'b0;
		case (cur.phase)
			ndp_pkg::SEC_HEADER: begin
				if (!cur.first_pending && cur.rec_cnt != ndp_pkg::REC_MAX)
					n.rec_cnt = cur.rec_cnt + 8'd1;
				n.header = data_byte;
				n.type_len = 8'd0;
				n.pay_len = 32'd0;
				n.id_len = 8'd0;
				n.len_cnt = 2'd0;
				if (cur.first_pending && (!data_byte[ndp_pkg::HDR_MB] ||
						data_byte[2:0] == ndp_pkg::TNF_UNCHANGED)) begin
					n.error_seen = 1'b1;
					n.phase = ndp_pkg::SEC_IGNORE;
				end else begin
					n.phase = ndp_pkg::SEC_TYPELEN;
				end
				n.first_pending = 1'b0;
			end
			ndp_pkg::SEC_TYPELEN: begin
				n.type_len = data_byte;
				n.pay_len = 32'd0;
				n.len_cnt = 2'd0;
				n.phase = ndp_pkg::SEC_PAYLEN;
			end
			ndp_pkg::SEC_PAYLEN: begin
				n.pay_len = {cur.pay_len[23:0], data_byte};
				if (cur.header[ndp_pkg::HDR_SR] || cur.len_cnt == ndp_pkg::LEN_LAST) begin
					if (cur.header[ndp_pkg::HDR_IL]) begin
						n.phase = ndp_pkg::SEC_IDLEN;
					end else begin
						hd = 1'b1;
						complete = 1'b1;
					end
				end else begin
					n.len_cnt = cur.len_cnt + 2'd1;
				end
			end
			ndp_pkg::SEC_IDLEN: begin
				n.id_len = data_byte;
				hd = 1'b1;
				complete = 1'b1;
			end
			ndp_pkg::SEC_TYPE, ndp_pkg::SEC_ID, ndp_pkg::SEC_PAYLOAD: begin
				n.remaining = rem_dec;
				adv = (rem_dec == 32'd0);
			end
			default: begin
				sec = ndp_pkg::SEC_IGNORE;
				n.error_seen = 1'b1;
				n.phase = ndp_pkg::SEC_IGNORE;
			end
		endcase

		tnf = n.header[2:0];
		bad = (tnf == ndp_pkg::TNF_EMPTY &&
				(n.type_len != 8'd0 || n.id_len != 8'd0 || n.pay_len != 32'd0)) ||
			(tnf == ndp_pkg::TNF_UNKNOWN && n.type_len != 8'd0);
		if (complete) begin
			if (bad) begin
				n.error_seen = 1'b1;
				n.phase = ndp_pkg::SEC_IGNORE;
			end else begin
				n = advance(n, ndp_pkg::SEC_IDLEN);
			end
		end
		if (adv)
			n = advance(n, sec);

		if (n.error_seen)
			st = ndp_pkg::ST_ERROR;
		else if (n.ended)
			st = ndp_pkg::ST_VALID;
		else if (last_byte)
			st = ndp_pkg::ST_ERROR;
		else
			st = ndp_pkg::ST_BUSY;

		res.out_byte = data_byte;
		res.section = sec;
		res.record_number = n.rec_cnt;
		res.header_done = hd;
		res.record_flags = n.header[7:3];
		res.record_tnf = n.header[2:0];
		res.type_len = n.type_len;
		res.payload_length = n.pay_len;
		res.id_len = n.id_len;
		res.status = st;

		// the last byte closes the message and rearms for the next one
		nxt = last_byte ? ndp_pkg::STATE_RESET : n;
	end

endmodule

// File: rtl/core/ndp_obuf.sv
module ndp_obuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ndp_pkg::result_t push_data,
	output logic             space,
	output logic             valid,
	output ndp_pkg::result_t data,
	input  logic             take
);

	logic             main_v_q;
	logic             skid_v_q;
	ndp_pkg::result_t main_q;
	ndp_pkg::result_t skid_q;
	logic             main_free;

	assign main_free = !main_v_q || take;
	assign space = !skid_v_q;
	assign valid = main_v_q;
	assign data = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (main_free) begin
			if (skid_v_q) begin
				main_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			main_q <= skid_v_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

`ifndef ASSERT_OFF
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> main_v_q) else $error("skid item without head item");
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && skid_v_q)) else $error("item pushed into full output buffer");
	a_head_kept: assert property (@(posedge clk) disable iff (!arst_n)
		main_v_q && !take |=> main_v_q && $stable(main_q))
		else $error("unconsumed head item lost");
`endif

endmodule

// File: verif/tb_ndef_message_parser_core.sv
module tb_ndef_message_parser_core;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 480;

	typedef struct {
		logic [7:0]       data;
		logic             last;
		logic             pinned;
		ndp_pkg::result_t tag;
	} stim_row_t;

	logic clk;
	logic arst_n;

	ndp_in_if  raw_if();
	ndp_out_if parsed_if();

	ndef_message_parser_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw_if),
		.parsed (parsed_if)
	);

	int               cycle_cnt;
	int               mismatches;
	int               bytes_sent;
	int               src_idle_pct;
	int               snk_idle_pct;
	ndp_pkg::result_t byte_tags_q[$];
	stim_row_t        directed_q[$];
	logic [7:0]       msg_q[$];

	// parser state mirrored by the predictor
	ndp_pkg::sec_t cur_section;
	logic [7:0]    hdr_byte;
	logic [7:0]    typ_len;
	logic [31:0]   pay_len;
	logic [7:0]    idf_len;
	logic [1:0]    len_bytes;
	logic [31:0]   bytes_left;
	logic [7:0]    rec_idx;
	logic          fmt_error;
	logic          msg_done;
	logic          at_first;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic void clear_parser();
		cur_section = ndp_pkg::SEC_HEADER;
		hdr_byte    = '0;
		typ_len     = '0;
		pay_len     = '0;
		idf_len     = '0;
		len_bytes   = '0;
		bytes_left  = '0;
		rec_idx     = '0;
		fmt_error   = 1'b0;
		msg_done    = 1'b0;
		at_first    = 1'b1;
	endfunction

	function automatic void finish_record();
		if (hdr_byte[ndp_pkg::HDR_ME]) begin
			msg_done    = 1'b1;
			cur_section = ndp_pkg::SEC_IGNORE;
		end else begin
			cur_section = ndp_pkg::SEC_HEADER;
		end
	endfunction

	// skip to the first data section after 'after' that has bytes in it, else finish the record
	function automatic void next_section(input ndp_pkg::sec_t after);
		if (after < ndp_pkg::SEC_TYPE && typ_len != 0) begin
			cur_section = ndp_pkg::SEC_TYPE;
			bytes_left  = {24'd0, typ_len};
		end else if (after < ndp_pkg::SEC_ID && idf_len != 0) begin
			cur_section = ndp_pkg::SEC_ID;
			bytes_left  = {24'd0, idf_len};
		end else if (after < ndp_pkg::SEC_PAYLOAD && pay_len != 0) begin
			cur_section = ndp_pkg::SEC_PAYLOAD;
			bytes_left  = pay_len;
		end else begin
			finish_record();
		end
	endfunction

	function automatic void check_lengths();
		logic bad;
		bad = 1'b0;
		if (hdr_byte[2:0] == ndp_pkg::TNF_EMPTY &&
				(typ_len != 0 || idf_len != 0 || pay_len != 0))
			bad = 1'b1;
		if (hdr_byte[2:0] == ndp_pkg::TNF_UNKNOWN && typ_len != 0)
			bad = 1'b1;
		if (bad) begin
			fmt_error   = 1'b1;
			cur_section = ndp_pkg::SEC_IGNORE;
		end else begin
			next_section(ndp_pkg::SEC_IDLEN);
		end
	endfunction

	function automatic ndp_pkg::result_t parse_byte(input logic [7:0] d, input logic l);
		ndp_pkg::result_t r;
		ndp_pkg::sec_t    sec;
		logic             hd;
		sec = cur_section;
		hd  = 1'b0;
		case (cur_section)
			ndp_pkg::SEC_HEADER: begin
				if (!at_first && rec_idx != ndp_pkg::REC_MAX)
					rec_idx++;
				hdr_byte  = d;
				typ_len   = '0;
				pay_len   = '0;
				idf_len   = '0;
				len_bytes = '0;
				if (at_first && (!d[ndp_pkg::HDR_MB] || d[2:0] == ndp_pkg::TNF_UNCHANGED)) begin
					fmt_error   = 1'b1;
					cur_section = ndp_pkg::SEC_IGNORE;
				end else begin
					cur_section = ndp_pkg::SEC_TYPELEN;
				end
				at_first = 1'b0;
			end
			ndp_pkg::SEC_TYPELEN: begin
				typ_len     = d;
				pay_len     = '0;
				len_bytes   = '0;
				cur_section = ndp_pkg::SEC_PAYLEN;
			end
			ndp_pkg::SEC_PAYLEN: begin
				pay_len = {pay_len[23:0], d};
				if (hdr_byte[ndp_pkg::HDR_SR] || len_bytes >= ndp_pkg::LEN_LAST) begin
					if (hdr_byte[ndp_pkg::HDR_IL]) begin
						cur_section = ndp_pkg::SEC_IDLEN;
					end else begin
						hd = 1'b1;
						check_lengths();
					end
				end else begin
					len_bytes++;
				end
			end
			ndp_pkg::SEC_IDLEN: begin
				idf_len = d;
				hd      = 1'b1;
				check_lengths();
			end
			ndp_pkg::SEC_TYPE, ndp_pkg::SEC_ID, ndp_pkg::SEC_PAYLOAD: begin
				if (bytes_left != 0)
					bytes_left--;
				if (bytes_left == 0)
					next_section(sec);
			end
			default: begin
				sec         = ndp_pkg::SEC_IGNORE;
				fmt_error   = 1'b1;
				cur_section = ndp_pkg::SEC_IGNORE;
			end
		endcase
		r.out_byte       = d;
		r.section        = sec;
		r.record_number  = rec_idx;
		r.header_done    = hd;
		r.record_flags   = hdr_byte[7:3];
		r.record_tnf     = hdr_byte[2:0];
		r.type_len       = typ_len;
		r.payload_length = pay_len;
		r.id_len         = idf_len;
		if (fmt_error)
			r.status = ndp_pkg::ST_ERROR;
		else if (msg_done)
			r.status = ndp_pkg::ST_VALID;
		else
			r.status = l ? ndp_pkg::ST_ERROR : ndp_pkg::ST_BUSY;
		if (l)
			clear_parser();
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 100)
			$display("mismatch at cycle %0d: %s", cycle_cnt, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	always @(posedge clk) begin : check_parsed
		ndp_pkg::result_t want;
		if (arst_n && parsed_if.valid && parsed_if.ready) begin
			if (byte_tags_q.size() == 0) begin
				report_mismatch("parsed item with nothing outstanding");
			end else begin
				want = byte_tags_q.pop_front();
				check_field("out_byte", 32'(parsed_if.out_byte), 32'(want.out_byte));
				check_field("section", 32'(parsed_if.section), 32'(want.section));
				check_field("record_number", 32'(parsed_if.record_number),
					32'(want.record_number));
				check_field("header_done", 32'(parsed_if.header_done),
					32'(want.header_done));
				check_field("record_flags", 32'(parsed_if.record_flags),
					32'(want.record_flags));
				check_field("record_tnf", 32'(parsed_if.record_tnf), 32'(want.record_tnf));
				check_field("type_len", 32'(parsed_if.type_len), 32'(want.type_len));
				check_field("payload_length", parsed_if.payload_length, want.payload_length);
				check_field("id_len", 32'(parsed_if.id_len), 32'(want.id_len));
				check_field("status", 32'(parsed_if.status), 32'(want.status));
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(negedge clk)
		parsed_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);

	// called on a falling edge, returns on the falling edge after acceptance
	task automatic send_byte(input logic [7:0] d, input logic l, input logic pinned,
			input ndp_pkg::result_t tag);
		ndp_pkg::result_t r;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			raw_if.valid <= 1'b0;
			@(negedge clk);
		end
		raw_if.valid     <= 1'b1;
		raw_if.data_byte <= d;
		raw_if.last_byte <= l;
		do
			@(posedge clk);
		while (!raw_if.ready);
		r = parse_byte(d, l);
		byte_tags_q.push_back(pinned ? tag : r);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_message();
		for (int i = 0; i < msg_q.size(); i++)
			send_byte(msg_q[i], i == msg_q.size() - 1, 1'b0, '0);
	endtask

	task automatic wait_drained();
		raw_if.valid <= 1'b0;
		while (byte_tags_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic void plain_row(input logic [7:0] d, input logic l);
		stim_row_t row;
		row.data   = d;
		row.last   = l;
		row.pinned = 1'b0;
		row.tag    = '0;
		directed_q.push_back(row);
	endfunction

	function automatic void pinned_row(input logic [7:0] d, input logic l,
			input ndp_pkg::result_t t);
		stim_row_t row;
		row.data   = d;
		row.last   = l;
		row.pinned = 1'b1;
		row.tag    = t;
		directed_q.push_back(row);
	endfunction

	// well-formed records with small random lengths, ME on the last one
	task automatic build_records(input int unsigned n_rec);
		logic [7:0]  hdr;
		logic [2:0]  tnf;
		logic [31:0] pl;
		int unsigned tl;
		int unsigned il;
		for (int unsigned i = 0; i < n_rec; i++) begin
			tnf = 3'($urandom_range(0, 7));
			if (i == 0 && tnf == ndp_pkg::TNF_UNCHANGED)
				tnf = {tnf[2:1], 1'b1};
			hdr                  = 8'($urandom_range(0, 255));
			hdr[2:0]             = tnf;
			hdr[ndp_pkg::HDR_ME] = (i == n_rec - 1);
			hdr[ndp_pkg::HDR_SR] = ($urandom_range(0, 3) != 0);
			if (i == 0)
				hdr[ndp_pkg::HDR_MB] = 1'b1;
			tl = $urandom_range(0, 4);
			il = hdr[ndp_pkg::HDR_IL] ? $urandom_range(0, 3) : 0;
			pl = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
			if (tnf == ndp_pkg::TNF_EMPTY) begin
				tl = 0;
				il = 0;
				pl = 0;
			end
			if (tnf == ndp_pkg::TNF_UNKNOWN)
				tl = 0;
			msg_q.push_back(hdr);
			msg_q.push_back(tl[7:0]);
			if (hdr[ndp_pkg::HDR_SR]) begin
				msg_q.push_back(pl[7:0]);
			end else begin
				msg_q.push_back(pl[31:24]);
				msg_q.push_back(pl[23:16]);
				msg_q.push_back(pl[15:8]);
				msg_q.push_back(pl[7:0]);
			end
			if (hdr[ndp_pkg::HDR_IL])
				msg_q.push_back(il[7:0]);
			repeat (tl + il + pl)
				msg_q.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		int          kind;
		int          stop_at;
		int unsigned keep;
		logic [7:0]  hdr;

		bytes_sent       = 0;
		src_idle_pct     = 38;
		snk_idle_pct     = 77;
		arst_n           = 1'b0;
		raw_if.valid     = 1'b0;
		raw_if.data_byte = '0;
		raw_if.last_byte = 1'b0;
		clear_parser();

		// first header without MB, then a byte that is ignored
		pinned_row(8'h11, 1'b0, ndp_pkg::result_t'{8'h11, ndp_pkg::SEC_HEADER, 8'd0, 1'b0,
			5'h02, 3'd1, 8'd0, 32'd0, 8'd0, ndp_pkg::ST_ERROR});
		pinned_row(8'hff, 1'b1, ndp_pkg::result_t'{8'hff, ndp_pkg::SEC_IGNORE, 8'd0, 1'b0,
			5'h02, 3'd1, 8'd0, 32'd0, 8'd0, ndp_pkg::ST_ERROR});
		// first record with tnf unchanged
		pinned_row(8'hd6, 1'b1, ndp_pkg::result_t'{8'hd6, ndp_pkg::SEC_HEADER, 8'd0, 1'b0,
			5'h1a, 3'd6, 8'd0, 32'd0, 8'd0, ndp_pkg::ST_ERROR});
		// empty record with a type length
		plain_row(8'hd0, 1'b0);
		plain_row(8'h01, 1'b0);
		pinned_row(8'h00, 1'b1, ndp_pkg::result_t'{8'h00, ndp_pkg::SEC_PAYLEN, 8'd0, 1'b1,
			5'h1a, 3'd0, 8'd1, 32'd0, 8'd0, ndp_pkg::ST_ERROR});
		// unknown record with a type length
		plain_row(8'hd5, 1'b0);
		plain_row(8'h02, 1'b0);
		pinned_row(8'h00, 1'b1, ndp_pkg::result_t'{8'h00, ndp_pkg::SEC_PAYLEN, 8'd0, 1'b1,
			5'h1a, 3'd5, 8'd2, 32'd0, 8'd0, ndp_pkg::ST_ERROR});
		// long payload length with an id
		plain_row(8'hc9, 1'b0);
		plain_row(8'h00, 1'b0);
		plain_row(8'h00, 1'b0);
		plain_row(8'h00, 1'b0);
		plain_row(8'h00, 1'b0);
		plain_row(8'h01, 1'b0);
		plain_row(8'h01, 1'b0);
		plain_row(8'hbb, 1'b0);
		pinned_row(8'hff, 1'b1, ndp_pkg::result_t'{8'hff, ndp_pkg::SEC_PAYLOAD, 8'd0, 1'b0,
			5'h19, 3'd1, 8'd0, 32'd1, 8'd1, ndp_pkg::ST_VALID});
		// byte trailing the ME record
		plain_row(8'hd1, 1'b0);
		plain_row(8'h00, 1'b0);
		plain_row(8'h00, 1'b0);
		pinned_row(8'h12, 1'b1, ndp_pkg::result_t'{8'h12, ndp_pkg::SEC_IGNORE, 8'd0, 1'b0,
			5'h1a, 3'd1, 8'd0, 32'd0, 8'd0, ndp_pkg::ST_ERROR});
		// message cut short after one byte
		pinned_row(8'hff, 1'b1, ndp_pkg::result_t'{8'hff, ndp_pkg::SEC_HEADER, 8'd0, 1'b0,
			5'h1f, 3'd7, 8'd0, 32'd0, 8'd0, ndp_pkg::ST_ERROR});
		// two records, the second one empty
		plain_row(8'h91, 1'b0);
		plain_row(8'h00, 1'b0);
		plain_row(8'h01, 1'b0);
		plain_row(8'h55, 1'b0);
		plain_row(8'h50, 1'b0);
		plain_row(8'h00, 1'b0);
		pinned_row(8'h00, 1'b1, ndp_pkg::result_t'{8'h00, ndp_pkg::SEC_PAYLEN, 8'd1, 1'b1,
			5'h0a, 3'd0, 8'd0, 32'd0, 8'd0, ndp_pkg::ST_VALID});

		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_q[i])
			send_byte(directed_q[i].data, directed_q[i].last, directed_q[i].pinned,
				directed_q[i].tag);
		// hold the sender until the parser has drained
		wait_drained();

		for (int ph = 0; ph < 3; ph++) begin
			src_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 77 : 0;
			snk_idle_pct = (ph == 0) ? 77 : (ph == 1) ? 38 : 0;
			stop_at      = bytes_sent + PHASE_ITEMS;
			if (ph == 2) begin
				// enough minimal records to saturate the record index
				msg_q.delete();
				for (int r = 0; r < 258; r++) begin
					hdr                  = 8'h00;
					hdr[2:0]             = ndp_pkg::TNF_EMPTY;
					hdr[ndp_pkg::HDR_SR] = 1'b1;
					hdr[ndp_pkg::HDR_MB] = (r == 0);
					hdr[ndp_pkg::HDR_ME] = (r == 257);
					msg_q.push_back(hdr);
					msg_q.push_back(8'h00);
					msg_q.push_back(8'h00);
				end
				send_message();
			end
			while (bytes_sent < stop_at) begin
				kind = $urandom_range(0, 99);
				msg_q.delete();
				if (kind < 70) begin
					build_records($urandom_range(1, 4));
					if ($urandom_range(0, 9) == 0)
						repeat ($urandom_range(1, 3))
							msg_q.push_back(8'($urandom_range(0, 255)));
				end else if (kind < 85) begin
					build_records($urandom_range(1, 4));
					if (msg_q.size() > 1) begin
						keep = $urandom_range(1, msg_q.size() - 1);
						while (msg_q.size() > keep)
							msg_q.delete(msg_q.size() - 1);
					end
				end else begin
					repeat ($urandom_range(1, 12))
						msg_q.push_back(8'($urandom_range(0, 255)));
					if ($urandom_range(0, 1))
						msg_q[0][ndp_pkg::HDR_MB] = 1'b1;
				end
				send_message();
			end
			wait_drained();
		end

		repeat (8)
			@(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
